@@ sv/blp_pkg.sv @@
// ----------------------------------------------------------------------------
// blp_pkg
// Shared types for the line point generator: request and result beats,
// controller state and the controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package blp_pkg;

  localparam int unsigned FIELD_BITS = 6;

  typedef struct packed {
    logic [FIELD_BITS-1:0] start_x;
    logic [FIELD_BITS-1:0] start_y;
    logic [FIELD_BITS-1:0] end_x;
    logic [FIELD_BITS-1:0] end_y;
  } req_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] point_index;
    logic [FIELD_BITS-1:0] point_value;
    logic                  last_point;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT_END,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic sel_end;
  } ctrl_cmd_t;

  typedef struct packed {
    logic at_end;
    logic next_at_end;
  } ctrl_stat_t;

endpackage

@@ sv/blp_datapath.sv @@
// ----------------------------------------------------------------------------
// blp_datapath
// Position, end point, deltas, step directions and error term of the walk;
// one Bresenham step per step command, result point selected by the controller.
// ----------------------------------------------------------------------------
module blp_datapath import blp_pkg::*; #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic       clk,
  input  req_t       request,
  input  ctrl_cmd_t  cmd,
  output ctrl_stat_t stat,
  output logic [FIELD_BITS-1:0] out_x,
  output logic [FIELD_BITS-1:0] out_y
);

  localparam int unsigned EW = COORD_BITS + 2;

  logic [COORD_BITS-1:0] x, y, ex, ey, dx, dy;
  logic                  sx, sy;
  logic signed [EW-1:0]  err;

  logic [COORD_BITS-1:0] lx, ly, lex, ley, ldx, ldy;
  logic signed [EW:0]    e2;
  logic signed [EW:0]    dx_s, dy_s;
  logic                  move_x, move_y;
  logic [COORD_BITS-1:0] x_next, y_next;
  logic signed [EW-1:0]  err_next;

  assign lx  = request.start_x[COORD_BITS-1:0];
  assign ly  = request.start_y[COORD_BITS-1:0];
  assign lex = request.end_x[COORD_BITS-1:0];
  assign ley = request.end_y[COORD_BITS-1:0];
  assign ldx = (lex > lx) ? lex - lx : lx - lex;
  assign ldy = (ley > ly) ? ley - ly : ly - ley;

  assign e2   = {err, 1'b0};
  assign dx_s = $signed({3'b000, dx});
  assign dy_s = $signed({3'b000, dy});

  always_comb begin
    move_x   = e2 > -dy_s;
    move_y   = e2 < dx_s;
    x_next   = x;
    y_next   = y;
    err_next = err;
    if (move_x) begin
      x_next   = sx ? x + 1'b1 : x - 1'b1;
      err_next = err_next - $signed(dy_s[EW-1:0]);
    end
    if (move_y) begin
      y_next   = sy ? y + 1'b1 : y - 1'b1;
      err_next = err_next + $signed(dx_s[EW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x   <= lx;
      y   <= ly;
      ex  <= lex;
      ey  <= ley;
      dx  <= ldx;
      dy  <= ldy;
      sx  <= lx < lex;
      sy  <= ly < ley;
      err <= $signed({2'b00, ldx}) - $signed({2'b00, ldy});
    end else if (cmd.step) begin
      x   <= x_next;
      y   <= y_next;
      err <= err_next;
    end
  end

  assign stat.at_end      = (x == ex) && (y == ey);
  assign stat.next_at_end = (x_next == ex) && (y_next == ey);

  assign out_x = FIELD_BITS'(cmd.sel_end ? ex : x);
  assign out_y = FIELD_BITS'(cmd.sel_end ? ey : y);

endmodule

@@ sv/blp_ctrl.sv @@
// ----------------------------------------------------------------------------
// blp_ctrl
// Run sequencer: end point beat first, then one walk beat per cycle until
// the step that reaches the end point.
// ----------------------------------------------------------------------------
module blp_ctrl import blp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd,
  output logic       busy,
  output logic       strobe,
  output logic       last
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EMIT_END;
      end
      ST_EMIT_END: begin
        state_next = stat.at_end ? ST_IDLE : ST_WALK;
      end
      ST_WALK: begin
        if (stat.next_at_end) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd    = '0;
    busy   = 1'b1;
    strobe = 1'b0;
    last   = 1'b0;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_EMIT_END: begin
        strobe      = 1'b1;
        cmd.sel_end = 1'b1;
        last        = stat.at_end;
      end
      ST_WALK: begin
        strobe   = 1'b1;
        cmd.step = 1'b1;
        last     = stat.next_at_end;
      end
      default: busy = 1'b0;
    endcase
  end

  // walk never shows the end point itself
  a_walk_not_end: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> !stat.at_end)
    else $error("walk reached end point");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> state == ST_IDLE)
    else $error("run continued after last beat");

  a_run_needs_start: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT_END |-> $past(start) && $past(state) == ST_IDLE)
    else $error("run began without a request");

  a_end_first: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> $past(state) == ST_EMIT_END || $past(state) == ST_WALK)
    else $error("walk began before end point beat");

endmodule

@@ sv/bresenham_line_points.sv @@
// ----------------------------------------------------------------------------
// bresenham_line_points
// A request with a start and an end point gives a run of result beats: the
// end point first, then every point of the Bresenham walk from the start
// toward the end, excluding the end point. last_point flags the final beat.
// A run of N = 1 + max(|dx|, |dy|) beats follows the accepting edge with one
// beat per cycle, the first in the cycle right after; busy drops after the
// last beat. Results carry no backpressure: each beat is on the result port
// for one cycle with strobe high and must be taken then.
// Coordinates use their low COORD_BITS bits only.
// ----------------------------------------------------------------------------
module bresenham_line_points import blp_pkg::*; #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic strobe,
  output res_t result
);

  ctrl_cmd_t             cmd;
  ctrl_stat_t            stat;
  logic                  last;
  logic [FIELD_BITS-1:0] out_x, out_y;

  blp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe),
    .last   (last)
  );

  blp_datapath #(.COORD_BITS(COORD_BITS)) u_datapath (
    .clk     (clk),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .out_x   (out_x),
    .out_y   (out_y)
  );

  assign result.point_index = out_x;
  assign result.point_value = out_y;
  assign result.last_point  = last;

endmodule

@@ bench/bresenham_line_points_test.sv @@
// ----------------------------------------------------------------------------
// bresenham_line_points_test
// Drives line requests into the point generator and checks every result beat
// against a local walk of the same all-octant error term: end point first,
// then each visited point short of the end, last beat flagged. Directed lines
// cover the corners, every octant and degenerate lines; random lines follow
// with varying sender gaps, and flagged requests wait for a full drain.
// ----------------------------------------------------------------------------
module bresenham_line_points_test;
  import blp_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned RUN_CYCLES  = 70;
  localparam int unsigned RANDOM_JOBS = 448;

  typedef struct {
    req_t line;
    bit   drain_first;
  } line_job_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t request = '0;
  logic strobe;
  res_t result;

  line_job_t   line_jobs[$];
  res_t        points_due[$];
  logic        all_points_in = 1'b1;
  int unsigned lines_sent = 0;
  int unsigned stall_cycles = 0;
  int unsigned error_count = 0;

  bresenham_line_points i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .strobe  (strobe),
    .result  (result)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int unsigned gap_percent(int unsigned sent);
    if (sent < 160) begin
      return 10;
    end else if (sent < 320) begin
      return 88;
    end
    return 0;
  endfunction

  function automatic void walk_line(req_t line);
    int   x, y, ex, ey, dx, dy, sx, sy, err, e2, n;
    res_t pt;
    x  = line.start_x;
    y  = line.start_y;
    ex = line.end_x;
    ey = line.end_y;
    dx = (ex > x) ? ex - x : x - ex;
    dy = (ey > y) ? ey - y : y - ey;
    sx = (x < ex) ? 1 : -1;
    sy = (y < ey) ? 1 : -1;
    err = dx - dy;
    pt.point_index = FIELD_BITS'(ex);
    pt.point_value = FIELD_BITS'(ey);
    pt.last_point  = 1'b0;
    points_due.push_back(pt);
    n = 1;
    while ((x != ex || y != ey) && n < (1 << FIELD_BITS)) begin
      e2 = 2 * err;
      pt.point_index = FIELD_BITS'(x);
      pt.point_value = FIELD_BITS'(y);
      points_due.push_back(pt);
      n++;
      if (e2 > -dy) begin
        err -= dy;
        x += sx;
      end
      if (e2 < dx) begin
        err += dx;
        y += sy;
      end
    end
    points_due[points_due.size() - 1].last_point = 1'b1;
  endfunction

  function automatic void add_line(int sx, int sy, int ex, int ey, bit drain = 1'b0);
    line_job_t job;
    job.line.start_x = FIELD_BITS'(sx);
    job.line.start_y = FIELD_BITS'(sy);
    job.line.end_x   = FIELD_BITS'(ex);
    job.line.end_y   = FIELD_BITS'(ey);
    job.drain_first  = drain;
    line_jobs.push_back(job);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (line_jobs.size() != 0 && $urandom_range(99) >= gap_percent(lines_sent) &&
          !(line_jobs[0].drain_first && (start || !all_points_in))) begin
        request <= line_jobs[0].line;
        start <= 1'b1;
        line_jobs.pop_front();
        lines_sent <= lines_sent + 1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor and prediction
  always @(posedge clk) begin
    res_t due;
    if (!rst) begin
      if (strobe) begin
        if (points_due.size() == 0) begin
          $display("%0t: unexpected beat index %0d value %0d last %0b", $time,
                   result.point_index, result.point_value, result.last_point);
          error_count++;
        end else begin
          due = points_due.pop_front();
          if (result !== due) begin
            $display("%0t: expected index %0d value %0d last %0b, got index %0d value %0d last %0b",
                     $time, due.point_index, due.point_value, due.last_point,
                     result.point_index, result.point_value, result.last_point);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        walk_line(request);
      end
      all_points_in <= (points_due.size() == 0);
      stall_cycles <= (strobe || (start && !busy)) ? 0 : stall_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[bresenham_line_points] ERROR");
      $finish;
    end
  end

  initial begin
    int sx, sy;
    // degenerate, corners, diagonals, axis lines
    add_line(0, 0, 0, 0);
    add_line(63, 63, 63, 63);
    add_line(17, 42, 17, 42);
    add_line(0, 0, 63, 63);
    add_line(63, 0, 0, 63);
    add_line(63, 63, 0, 0);
    add_line(0, 63, 63, 0);
    add_line(0, 0, 63, 0);
    add_line(0, 63, 0, 0);
    add_line(0, 0, 63, 1);
    add_line(0, 0, 1, 63);
    add_line(63, 63, 1, 0);
    add_line(5, 7, 6, 7);
    add_line(10, 10, 10, 11);
    // one line per octant
    add_line(32, 32, 63, 40);
    add_line(32, 32, 40, 63);
    add_line(32, 32, 24, 63);
    add_line(32, 32, 0, 40);
    add_line(32, 32, 0, 24);
    add_line(32, 32, 24, 0);
    add_line(32, 32, 40, 0, 1'b1);
    add_line(32, 32, 63, 24);
    add_line(42, 21, 21, 42);
    add_line(21, 42, 42, 21);
    for (int i = 0; i < RANDOM_JOBS; i++) begin
      sx = $urandom_range(63);
      sy = $urandom_range(63);
      case ($urandom_range(7))
        0: add_line(sx, sy, sx, sy);
        1: add_line(sx, sy, $urandom_range(63), sy);
        2: add_line(sx, sy, sx, $urandom_range(63));
        3: add_line(sx, sy, $urandom_range(sx > 60 ? 63 : sx + 3, sx > 3 ? sx - 3 : 0),
                    $urandom_range(63));
        default: add_line(sx, sy, $urandom_range(63), $urandom_range(63),
                          i == RANDOM_JOBS / 2);
      endcase
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (line_jobs.size() != 0 || start || !all_points_in) begin
      @(negedge clk);
    end
    repeat (RUN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (error_count == 0 && points_due.size() == 0) begin
      $display("[bresenham_line_points] OK");
    end else begin
      $display("[bresenham_line_points] ERROR");
    end
    $finish;
  end

endmodule
